@@ src/assert_macros.svh @@
// Assertion macros shared by the Julia pixel unit RTL.
// No dependencies; compiled away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ src/jsep_pkg.sv @@
// Package for the Julia set escape-time pixel unit: payload, config and
// control types, register indexes, constants and saturation helper. No deps.
`timescale 1ns / 1ps

package jsep_pkg;

  typedef struct packed {
    logic [9:0] column;
    logic [9:0] row;
  } req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] iterations;
  } res_t;

  typedef struct packed {
    logic [31:0] start_re;
    logic [31:0] start_im;
    logic [31:0] step_re;
    logic [31:0] step_im;
    logic [31:0] const_re;
    logic [31:0] const_im;
    logic [7:0]  max_iter;
    logic [10:0] image_width;
  } cfg_t;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_START_RE    = 3'd0;
  localparam logic [2:0] REG_START_IM    = 3'd1;
  localparam logic [2:0] REG_STEP_RE     = 3'd2;
  localparam logic [2:0] REG_STEP_IM     = 3'd3;
  localparam logic [2:0] REG_CONST_RE    = 3'd4;
  localparam logic [2:0] REG_CONST_IM    = 3'd5;
  localparam logic [2:0] REG_MAX_ITER    = 3'd6;
  localparam logic [2:0] REG_IMAGE_WIDTH = 3'd7;

  localparam logic [31:0] RST_START_RE    = 32'(-429496730);
  localparam logic [31:0] RST_START_IM    = 32'(-295279002);
  localparam logic [31:0] RST_STEP_RE     = 32'(3019899);
  localparam logic [31:0] RST_STEP_IM     = 32'(2460658);
  localparam logic [31:0] RST_CONST_RE    = 32'(-107374182);
  localparam logic [31:0] RST_CONST_IM    = 32'(161061274);
  localparam logic [7:0]  RST_MAX_ITER    = 8'd60;
  localparam logic [10:0] RST_IMAGE_WIDTH = 11'd320;

  // escape bound 4.0 in Q8.56
  localparam logic [63:0] ESC_BOUND = 64'h0400_0000_0000_0000;

  // color gains: 9*255, 15*255, 2*8.5*255
  localparam logic [12:0] K_RED   = 13'd2295;
  localparam logic [12:0] K_GREEN = 13'd3825;
  localparam logic [12:0] K_BLUE  = 13'd4335;

  // quotient bits of t = count * 2^16 / max_iter
  localparam logic [4:0] DIV_STEPS = 5'd17;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_MUL,
    ST_INIT_SUM,
    ST_ITER_MUL,
    ST_ITER_CHK,
    ST_DIV,
    ST_COL_MUL1,
    ST_COL_MUL2,
    ST_COL_HI,
    ST_COL_LO,
    ST_COL_OUT
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT_MUL,
    OP_INIT_SUM,
    OP_ITER_MUL,
    OP_ITER_UPD,
    OP_DIV_STEP,
    OP_COL_MUL1,
    OP_COL_MUL2,
    OP_COL_HI,
    OP_COL_LO,
    OP_COL_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic cont;  // iterate again: count below limit and |z|^2 < 4
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ src/jsep_ctrl.sv @@
// Sequencer for the Julia pixel unit: walks init, iteration, divide and
// color steps and issues datapath commands. Depends on jsep_pkg.
`timescale 1ns / 1ps

module jsep_ctrl import jsep_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  ctrl_state_e state_q, state_d;
  logic [4:0]  div_cnt_q, div_cnt_d;

  // next state
  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_INIT_MUL;
        end
      end
      ST_INIT_MUL: state_d = ST_INIT_SUM;
      ST_INIT_SUM: state_d = ST_ITER_MUL;
      ST_ITER_MUL: state_d = ST_ITER_CHK;
      ST_ITER_CHK: begin
        div_cnt_d = '0;
        state_d   = sts_i.cont ? ST_ITER_MUL : ST_DIV;
      end
      ST_DIV: begin
        div_cnt_d = div_cnt_q + 5'd1;
        if (div_cnt_q == DIV_STEPS - 5'd1) begin
          state_d = ST_COL_MUL1;
        end
      end
      ST_COL_MUL1: state_d = ST_COL_MUL2;
      ST_COL_MUL2: state_d = ST_COL_HI;
      ST_COL_HI:   state_d = ST_COL_LO;
      ST_COL_LO:   state_d = ST_COL_OUT;
      ST_COL_OUT:  state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy_o    = (state_q != ST_IDLE);
    cmd_o.op  = OP_NONE;
    case (state_q)
      ST_IDLE:     cmd_o.op = start_i ? OP_LOAD : OP_NONE;
      ST_INIT_MUL: cmd_o.op = OP_INIT_MUL;
      ST_INIT_SUM: cmd_o.op = OP_INIT_SUM;
      ST_ITER_MUL: cmd_o.op = OP_ITER_MUL;
      ST_ITER_CHK: cmd_o.op = OP_ITER_UPD;
      ST_DIV:      cmd_o.op = OP_DIV_STEP;
      ST_COL_MUL1: cmd_o.op = OP_COL_MUL1;
      ST_COL_MUL2: cmd_o.op = OP_COL_MUL2;
      ST_COL_HI:   cmd_o.op = OP_COL_HI;
      ST_COL_LO:   cmd_o.op = OP_COL_LO;
      ST_COL_OUT:  cmd_o.op = OP_COL_OUT;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
    end
  end

endmodule

@@ src/jsep_dp.sv @@
// Datapath for the Julia pixel unit: three shared multipliers, the z
// registers, iteration count, radix-2 divider and color sums. Uses jsep_pkg.
`timescale 1ns / 1ps

module jsep_dp import jsep_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  input  req_t req_i,
  input  cfg_t cfg_i,
  output logic done_o,
  output res_t res_o
);

  logic [9:0]         col_q, row_q;
  logic signed [31:0] re_q, re_d, im_q, im_d;
  logic [7:0]         cnt_q, cnt_d;
  logic [63:0]        pa_q, pb_q, pc_q;
  logic [44:0]        ha_q, hb_q, hc_q;
  logic [8:0]         rem_q, rem_d;
  logic [16:0]        t_q, t_d;
  res_t               res_q, res_d;
  logic               done_q;

  // multiplier lanes
  logic signed [32:0] ma_a, ma_b, mb_a, mb_b, mc_a, mc_b;
  logic signed [65:0] ma_p, mb_p, mc_p;

  logic signed [11:0] col_off;
  logic [15:0]        t16, u16;
  logic [63:0]        mag;
  logic signed [63:0] dre, nre_w, nim_w, sre_w, sim_w;
  logic               div_bit;
  logic [7:0]         div_rem;
  logic               t_zero;
  logic [44:0]        sr, sg, sb;

  assign col_off = $signed({1'b0, cfg_i.image_width}) - $signed({2'b00, col_q});
  assign t16     = t_q[15:0];
  assign u16     = ~t_q[15:0] + 16'd1;

  always_comb begin
    ma_a = '0; ma_b = '0; mb_a = '0; mb_b = '0; mc_a = '0; mc_b = '0;
    case (cmd_i.op)
      OP_INIT_MUL: begin
        ma_a = {{21{col_off[11]}}, col_off};
        ma_b = {cfg_i.step_re[31], cfg_i.step_re};
        mb_a = {23'b0, row_q};
        mb_b = {cfg_i.step_im[31], cfg_i.step_im};
      end
      OP_ITER_MUL: begin
        ma_a = {re_q[31], re_q};
        ma_b = {re_q[31], re_q};
        mb_a = {im_q[31], im_q};
        mb_b = {im_q[31], im_q};
        mc_a = {re_q[31], re_q};
        mc_b = {im_q[31], im_q};
      end
      OP_COL_MUL1: begin  // u*t, t*t, u*u
        ma_a = {17'b0, u16};
        ma_b = {17'b0, t16};
        mb_a = {17'b0, t16};
        mb_b = {17'b0, t16};
        mc_a = {17'b0, u16};
        mc_b = {17'b0, u16};
      end
      OP_COL_MUL2: begin  // u*t^3, u^2*t^2, u^3*t
        ma_a = {1'b0, pa_q[31:0]};
        ma_b = {1'b0, pb_q[31:0]};
        mb_a = {1'b0, pa_q[31:0]};
        mb_b = {1'b0, pa_q[31:0]};
        mc_a = {1'b0, pa_q[31:0]};
        mc_b = {1'b0, pc_q[31:0]};
      end
      OP_COL_HI: begin
        ma_a = {1'b0, pa_q[63:32]};
        ma_b = {20'b0, K_RED};
        mb_a = {1'b0, pb_q[63:32]};
        mb_b = {20'b0, K_GREEN};
        mc_a = {1'b0, pc_q[63:32]};
        mc_b = {20'b0, K_BLUE};
      end
      OP_COL_LO: begin
        ma_a = {1'b0, pa_q[31:0]};
        ma_b = {20'b0, K_RED};
        mb_a = {1'b0, pb_q[31:0]};
        mb_b = {20'b0, K_GREEN};
        mc_a = {1'b0, pc_q[31:0]};
        mc_b = {20'b0, K_BLUE};
      end
      default: ;
    endcase
  end

  assign ma_p = ma_a * ma_b;
  assign mb_p = mb_a * mb_b;
  assign mc_p = mc_a * mc_b;

  // escape test and next iterate
  assign mag        = pa_q + pb_q;
  assign sts_o.cont = (cnt_q < cfg_i.max_iter) && (mag < ESC_BOUND);
  assign dre        = $signed(pa_q) - $signed(pb_q);
  assign nre_w = (dre >>> 28) + $signed({{32{cfg_i.const_re[31]}}, cfg_i.const_re});
  assign nim_w = ($signed(pc_q) >>> 27)
               + $signed({{32{cfg_i.const_im[31]}}, cfg_i.const_im});
  assign sre_w = $signed({{32{cfg_i.start_re[31]}}, cfg_i.start_re}) + $signed(pa_q);
  assign sim_w = $signed({{32{cfg_i.start_im[31]}}, cfg_i.start_im}) + $signed(pb_q);

  // long division step, remainder stays below max_iter
  assign div_bit = (rem_q >= {1'b0, cfg_i.max_iter});
  assign div_rem = div_bit ? 8'(rem_q - {1'b0, cfg_i.max_iter}) : rem_q[7:0];

  // t of 0 or 1.0 gives black; so does a zero limit
  assign t_zero = (cfg_i.max_iter == 8'd0) || (t_q[15:0] == 16'd0) || t_q[16];
  assign sr     = ha_q + {13'b0, pa_q[63:32]};
  assign sg     = hb_q + {13'b0, pb_q[63:32]};
  assign sb     = hc_q + {13'b0, pc_q[63:32]};

  always_comb begin
    re_d  = re_q;
    im_d  = im_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    t_d   = t_q;
    res_d = res_q;
    case (cmd_i.op)
      OP_LOAD: cnt_d = '0;
      OP_INIT_SUM: begin
        re_d = sat32(sre_w);
        im_d = sat32(sim_w);
      end
      OP_ITER_UPD: begin
        if (sts_o.cont) begin
          re_d  = sat32(nre_w);
          im_d  = sat32(nim_w);
          cnt_d = cnt_q + 8'd1;
        end else begin
          rem_d = {1'b0, cnt_q};
          t_d   = '0;
        end
      end
      OP_DIV_STEP: begin
        rem_d = {div_rem, 1'b0};
        t_d   = {t_q[15:0], div_bit};
      end
      OP_COL_OUT: begin
        res_d.red        = t_zero ? 8'd0 : sr[39:32];
        res_d.green      = t_zero ? 8'd0 : sg[39:32];
        res_d.blue       = t_zero ? 8'd0 : sb[40:33];
        res_d.iterations = cnt_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      col_q <= req_i.column;
      row_q <= req_i.row;
    end
    case (cmd_i.op)
      OP_INIT_MUL, OP_ITER_MUL, OP_COL_MUL1, OP_COL_MUL2, OP_COL_LO: begin
        pa_q <= ma_p[63:0];
        pb_q <= mb_p[63:0];
        pc_q <= mc_p[63:0];
      end
      OP_COL_HI: begin
        ha_q <= ma_p[44:0];
        hb_q <= mb_p[44:0];
        hc_q <= mc_p[44:0];
      end
      default: ;
    endcase
    re_q  <= re_d;
    im_q  <= im_d;
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    t_q   <= t_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (cmd_i.op == OP_COL_OUT);
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ src/julia_set_escape_time_pixel_unit.sv @@
// Top level of the Julia set escape-time pixel unit: APB register file,
// sequencer and datapath. Depends on jsep_pkg, jsep_ctrl, jsep_dp, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   Request channel: drive req_i (column, row) and raise start while busy is
//   low; the request is taken at that clock edge and busy rises next cycle.
//   Result channel: done_o pulses for one cycle with res_o holding red,
//   green, blue and the iteration count. The receiver cannot hold it off;
//   res_o stays put until the next result, but only the strobed cycle counts.
//   Config: APB, registers at byte address 4*i (start_re, start_im, step_re,
//   step_im, const_re, const_im, max_iter, image_width). pready is tied high.
//   Write only while busy is low.
// Sequence (n = iterations returned)
//   Form z0, then n iterations on the shared multipliers (a multiply step and
//   an update step each) plus one final escape check, a radix-2 divide for
//   t = n/max_iter, then the color products. busy drops in the done cycle,
//   so a new request can be taken from then on; one request at a time.
// Reset
//   rst_ni is asynchronous, active low: sequencer idle, no strobe, config
//   registers return to their default view of the Julia set.

module julia_set_escape_time_pixel_unit import jsep_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  // result
  output logic        done_o,
  output res_t        res_o,
  // config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // register file; index taken from the word address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_re    <= RST_START_RE;
      cfg_q.start_im    <= RST_START_IM;
      cfg_q.step_re     <= RST_STEP_RE;
      cfg_q.step_im     <= RST_STEP_IM;
      cfg_q.const_re    <= RST_CONST_RE;
      cfg_q.const_im    <= RST_CONST_IM;
      cfg_q.max_iter    <= RST_MAX_ITER;
      cfg_q.image_width <= RST_IMAGE_WIDTH;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_START_RE:    cfg_q.start_re    <= pwdata;
        REG_START_IM:    cfg_q.start_im    <= pwdata;
        REG_STEP_RE:     cfg_q.step_re     <= pwdata;
        REG_STEP_IM:     cfg_q.step_im     <= pwdata;
        REG_CONST_RE:    cfg_q.const_re    <= pwdata;
        REG_CONST_IM:    cfg_q.const_im    <= pwdata;
        REG_MAX_ITER:    cfg_q.max_iter    <= pwdata[7:0];
        REG_IMAGE_WIDTH: cfg_q.image_width <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_START_RE:    prdata = cfg_q.start_re;
      REG_START_IM:    prdata = cfg_q.start_im;
      REG_STEP_RE:     prdata = cfg_q.step_re;
      REG_STEP_IM:     prdata = cfg_q.step_im;
      REG_CONST_RE:    prdata = cfg_q.const_re;
      REG_CONST_IM:    prdata = cfg_q.const_im;
      REG_MAX_ITER:    prdata = {24'b0, cfg_q.max_iter};
      REG_IMAGE_WIDTH: prdata = {21'b0, cfg_q.image_width};
      default:         prdata = '0;
    endcase
  end

  // sequencer: one request at a time
  jsep_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  // datapath: z iteration, divide, color map, result register
  jsep_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .req_i  (req_i),
    .cfg_i  (cfg_q),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // accepted request puts the unit to work
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  // a result only ends a busy stretch
  `ASSERT_IMPL(a_done_after_busy, clk_i, rst_ni, done_o, $past(busy))
  // one strobe per request
  `ASSERT_NEXT(a_single_strobe, clk_i, rst_ni, done_o, !done_o)
  // zero iterations means t = 0, so red, green and blue (res_o[31:8]) are all zero
  `ASSERT_IMPL(a_zero_black, clk_i, rst_ni, done_o && res_o.iterations == '0, res_o[31:8] == '0)

endmodule

@@ bench/jsep_pixel_checker.sv @@
// Checker for the Julia pixel unit: keeps its own register copy, predicts each pixel
// and compares every strobed result in order. Depends on jsep_pkg.
`timescale 1ns / 1ps

module jsep_pixel_checker import jsep_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  req_t        req_i,
  input  logic        done_o,
  input  res_t        res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          mismatch_count,
  output int          pixels_in_flight
);

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  logic signed [31:0] view_start_re, view_start_im, view_step_re, view_step_im;
  logic signed [31:0] julia_re, julia_im;
  logic [7:0]         iter_limit;
  logic [10:0]        mirror_width;

  res_t expected_pixels[$];

  assign pixels_in_flight = expected_pixels.size();

  function automatic logic signed [31:0] clamp_q428(input longint v);
    if (v > Q_MAX) return 32'sh7FFF_FFFF;
    if (v < Q_MIN) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // floor(x * k / 2^shift), exact in 80 bits
  function automatic logic [7:0] color_gain(input logic [63:0] x, input logic [12:0] k,
                                            input int shift);
    logic [79:0] p;
    p = 80'(x) * 80'(k);
    return 8'(p >> shift);
  endfunction

  function automatic res_t predict_pixel(input req_t px);
    longint      re, im, rr, ii, ri;
    logic [63:0] mag, t, u, ut;
    int          count;
    res_t        r;
    // column is mirrored about the image width
    re = clamp_q428(longint'(view_start_re) +
                    (longint'(mirror_width) - longint'(px.column)) * longint'(view_step_re));
    im = clamp_q428(longint'(view_start_im) + longint'(px.row) * longint'(view_step_im));
    count = 0;
    while (count < int'(iter_limit)) begin
      rr = re * re;
      ii = im * im;
      ri = re * im;
      mag = rr + ii;  // Q8.56, fits unsigned
      if (mag >= ESC_BOUND) break;
      re = clamp_q428(((rr - ii) >>> 28) + longint'(julia_re));
      im = clamp_q428((ri >>> 27) + longint'(julia_im));
      count++;
    end
    t = '0;
    if (iter_limit != 0) t = (64'(count) << 16) / 64'(iter_limit);
    u = 64'd65536 - t;
    ut = u * t;
    r.red        = color_gain(ut * t * t, K_RED, 64);
    r.green      = color_gain(ut * ut, K_GREEN, 64);
    r.blue       = color_gain(ut * u * u, K_BLUE, 65);
    r.iterations = 8'(count);
    return r;
  endfunction

  function automatic logic [31:0] reg_view(input logic [2:0] idx);
    case (idx)
      REG_START_RE:    return view_start_re;
      REG_START_IM:    return view_start_im;
      REG_STEP_RE:     return view_step_re;
      REG_STEP_IM:     return view_step_im;
      REG_CONST_RE:    return julia_re;
      REG_CONST_IM:    return julia_im;
      REG_MAX_ITER:    return {24'd0, iter_limit};
      default:         return {21'd0, mirror_width};
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      view_start_re <= RST_START_RE;
      view_start_im <= RST_START_IM;
      view_step_re  <= RST_STEP_RE;
      view_step_im  <= RST_STEP_IM;
      julia_re      <= RST_CONST_RE;
      julia_im      <= RST_CONST_IM;
      iter_limit    <= RST_MAX_ITER;
      mirror_width  <= RST_IMAGE_WIDTH;
      expected_pixels.delete();
      mismatch_count = 0;
    end else begin
      if (start && !busy) expected_pixels.push_back(predict_pixel(req_i));
      if (done_o) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: result with no request pending, got %h", $realtime, res_o);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("red", want.red, res_o.red);
          check_field("green", want.green, res_o.green);
          check_field("blue", want.blue, res_o.blue);
          check_field("iterations", want.iterations, res_o.iterations);
        end
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[4:2])
            REG_START_RE:    view_start_re <= pwdata;
            REG_START_IM:    view_start_im <= pwdata;
            REG_STEP_RE:     view_step_re  <= pwdata;
            REG_STEP_IM:     view_step_im  <= pwdata;
            REG_CONST_RE:    julia_re      <= pwdata;
            REG_CONST_IM:    julia_im      <= pwdata;
            REG_MAX_ITER:    iter_limit    <= pwdata[7:0];
            REG_IMAGE_WIDTH: mirror_width  <= pwdata[10:0];
            default: ;
          endcase
        end else begin
          check_field("register readback", reg_view(paddr[4:2]), prdata);
        end
      end
    end
  end

endmodule

@@ bench/testbench.sv @@
// Top of the Julia pixel unit bench: clock, reset, pixel requests and APB setup.
// Depends on jsep_pkg, jsep_pixel_checker and the unit itself.
`timescale 1ns / 1ps

module testbench;
  import jsep_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req_i;
  logic        done_o;
  res_t        res_o;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatch_count;
  int pixels_in_flight;
  int idle_pct;  // chance per cycle that the request side holds back

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  julia_set_escape_time_pixel_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .done_o  (done_o),
    .res_o   (res_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  jsep_pixel_checker pixel_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_i            (req_i),
    .done_o           (done_o),
    .res_o            (res_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .mismatch_count   (mismatch_count),
    .pixels_in_flight (pixels_in_flight)
  );

  // Offer one pixel request. start stays high after the accept edge so that
  // back-to-back requests never lower and raise it within one step; busy is
  // looked at on the falling edge, where it holds what the next rising edge sees.
  task automatic send_pixel(input logic [9:0] col, input logic [9:0] row);
    logic taken;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{column: col, row: row};
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic send_random_pixels(input int n);
    repeat (n) send_pixel(10'($urandom_range(1023)), 10'($urandom_range(1023)));
    start <= 1'b0;
  endtask

  // Wait until the unit is idle and every result is in; start is already low.
  task automatic drain;
    do @(negedge clk_i); while (pixels_in_flight != 0 || busy);
    @(posedge clk_i);
  endtask

  // One APB transfer: setup, access, then a quiet phase with psel low so that back-to-back
  // transfers never assign psel twice in one step.
  task automatic apb_transfer(input logic wr, input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // write, then read back (the checker compares the readback)
  task automatic set_reg(input logic [2:0] idx, input logic [31:0] data);
    apb_transfer(1'b1, idx, data);
    apb_transfer(1'b0, idx, '0);
  endtask

  // Q4.28 value in [-span, span], or plain noise one time in four
  function automatic logic [31:0] pick_q428(input int unsigned span);
    if ($urandom_range(3) == 0) return $urandom();
    return $urandom_range(2 * span) - span;
  endfunction

  // A random view of the plane: mostly sensible windows and constants with
  // |c| near the interesting region, sometimes arbitrary register contents.
  task automatic random_view;
    logic [31:0] step;
    set_reg(REG_START_RE, pick_q428(32'h2000_0000));
    set_reg(REG_START_IM, pick_q428(32'h2000_0000));
    step = $urandom_range(32'h0040_0000);
    set_reg(REG_STEP_RE, $urandom_range(1) ? step : -step);
    step = $urandom_range(32'h0040_0000);
    set_reg(REG_STEP_IM, $urandom_range(3) == 0 ? $urandom() : step);
    set_reg(REG_CONST_RE, pick_q428(32'h1000_0000));
    set_reg(REG_CONST_IM, pick_q428(32'h1000_0000));
    case ($urandom_range(7))
      0:       set_reg(REG_MAX_ITER, 32'd255);
      1:       set_reg(REG_MAX_ITER, 32'd0);
      default: set_reg(REG_MAX_ITER, $urandom_range(1, 100));
    endcase
    if ($urandom_range(4) == 0) set_reg(REG_IMAGE_WIDTH, $urandom_range(2047));
    else set_reg(REG_IMAGE_WIDTH, $urandom_range(1, 1024));
  endtask

  initial begin
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    req_i   <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    idle_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset view: corners, the mirror axis, a column past the width
    // (negative offset) and alternating bit patterns, back to back.
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd320, 10'd512);
    send_pixel(10'd321, 10'd100);
    send_pixel(10'h2AA, 10'h155);
    send_pixel(10'h155, 10'h2AA);
    send_pixel(10'd160, 10'd120);
    send_random_pixels(250);

    // Deepest iteration limit: interior points run all 255 rounds.
    drain();
    set_reg(REG_MAX_ITER, 32'd255);
    idle_pct = 62;
    send_pixel(10'd160, 10'd120);
    send_pixel(10'd200, 10'd200);
    send_pixel(10'd100, 10'd50);
    send_random_pixels(80);

    // Zero limit gives black with no iterations; zero width mirrors every
    // nonzero column to a negative offset.
    drain();
    set_reg(REG_MAX_ITER, 32'd0);
    set_reg(REG_IMAGE_WIDTH, 32'd0);
    idle_pct = 23;
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_random_pixels(60);

    // Register extremes: start points and iterates saturate in Q4.28.
    drain();
    set_reg(REG_START_RE, 32'h7FFF_FFFF);
    set_reg(REG_START_IM, 32'h8000_0000);
    set_reg(REG_STEP_RE, 32'h7FFF_FFFF);
    set_reg(REG_STEP_IM, 32'h8000_0000);
    set_reg(REG_CONST_RE, 32'h8000_0000);
    set_reg(REG_CONST_IM, 32'h7FFF_FFFF);
    set_reg(REG_MAX_ITER, 32'd1);
    set_reg(REG_IMAGE_WIDTH, 32'd2047);
    idle_pct = 0;
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_random_pixels(60);

    // Random views, cycling the request-side idle mix.
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      random_view();
      case (phase % 3)
        0:       idle_pct = 62;
        1:       idle_pct = 23;
        default: idle_pct = 0;
      endcase
      send_random_pixels(120);
    end

    // Let every result land, then allow for one full worst-case pixel so a
    // stray extra strobe would still be caught.
    drain();
    repeat (540) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("julia_set_escape_time_pixel_unit test passed");
    end else begin
      $display("julia_set_escape_time_pixel_unit test failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #30_000_000;
    $display("julia_set_escape_time_pixel_unit test failed");
    $finish;
  end

endmodule
